// ===== rtl/core/dedup_table_with_expiry_core_macros.svh =====
// Assertion macros of the checker file of the dedup table core.
`ifndef DEDUP_TABLE_WITH_EXPIRY_CORE_MACROS_SVH
`define DEDUP_TABLE_WITH_EXPIRY_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define DEDUP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dedup core check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define DEDUP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dedup core check failed");

`endif

// ===== rtl/core/dedup_pkg.sv =====
// Shared types and constants of the dedup table core.
`timescale 1ns / 1ps
package dedup_pkg;

  localparam int ENTRIES    = 16;
  localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W      = $clog2(ENTRIES + 1);
  localparam int OUT_CNT_W  = 5;
  localparam int KEY_W      = 64;
  localparam int TIME_W     = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int REG_IDX_W  = CFG_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_RETENTION   = '0;
  localparam logic [TIME_W-1:0]    RETENTION_RESET = 32'd3600;

  typedef enum logic [1:0] {
    KIND_QUERY = 2'd0,
    KIND_MARK  = 2'd1,
    KIND_SWEEP = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  typedef struct packed {
    logic load;    // latch the item and reset the slot trackers
    logic scan;    // read the slot at the scan index and advance
    logic finish;  // apply the item and register its result
  } cmd_t;

  typedef struct packed {
    logic op_clear;
    logic last_idx;
  } sts_t;

endpackage

// ===== rtl/core/dedup_ctrl.sv =====
// Sequencer of the dedup table core: walks the slots once per item, except for a clear.
`timescale 1ns / 1ps
module dedup_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  dedup_pkg::sts_t   sts,
  output dedup_pkg::cmd_t   cmd,
  output logic              busy
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_LAST = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.op_clear) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.scan = 1'b1;
          if (sts.last_idx) state_nxt = ST_LAST;
        end
      end
      // last slot read is evaluated here
      ST_LAST: state_nxt = ST_DONE;
      ST_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// ===== rtl/core/dedup_dp.sv =====
// Datapath of the dedup table core: key memory, valid bits, slot trackers, result.
`timescale 1ns / 1ps
module dedup_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  dedup_pkg::cmd_t                       cmd,
  output dedup_pkg::sts_t                       sts,
  input  logic [1:0]                            in_kind,
  input  logic [dedup_pkg::KEY_W-1:0]           in_key_high,
  input  logic [dedup_pkg::KEY_W-1:0]           in_key_low,
  input  logic [dedup_pkg::TIME_W-1:0]          in_now_seconds,
  input  logic [dedup_pkg::TIME_W-1:0]          retention,
  output logic                                  out_valid,
  output logic                                  out_duplicate,
  output logic                                  out_full_res,
  output logic [dedup_pkg::OUT_CNT_W-1:0]       out_entry_count
);

  localparam int MEM_W = 2 * dedup_pkg::KEY_W + dedup_pkg::TIME_W;

  logic [MEM_W-1:0] mem [dedup_pkg::ENTRIES];

  dedup_pkg::kind_t                kind_r;
  logic [dedup_pkg::KEY_W-1:0]     key_hi_r, key_lo_r;
  logic [dedup_pkg::TIME_W-1:0]    now_r;

  logic [dedup_pkg::IDX_W-1:0]     idx_r;
  logic                            rd_vld_r;
  logic [dedup_pkg::IDX_W-1:0]     rd_idx_r;
  logic [MEM_W-1:0]                rd_data_r;

  logic [dedup_pkg::ENTRIES-1:0]   valid_r, valid_nxt;
  logic [dedup_pkg::CNT_W-1:0]     count_r, count_nxt;

  logic                            match_f_r, match_exp_r, free_f_r, exp_f_r;
  logic [dedup_pkg::IDX_W-1:0]     match_idx_r, free_idx_r, exp_idx_r;

  logic                            out_valid_r, dup_r, full_r;
  logic [dedup_pkg::CNT_W-1:0]     out_cnt_r;

  logic                            slot_v, hit, expired, wr_en, dup_nxt, full_nxt;
  logic [dedup_pkg::IDX_W-1:0]     wr_idx;
  logic [dedup_pkg::TIME_W-1:0]    age;
  logic [31:0]                     cnt_ext;

  assign slot_v  = valid_r[rd_idx_r];
  assign hit     = slot_v
                   && (rd_data_r[MEM_W-1 -: dedup_pkg::KEY_W] == key_hi_r)
                   && (rd_data_r[dedup_pkg::KEY_W+dedup_pkg::TIME_W-1 -: dedup_pkg::KEY_W]
                       == key_lo_r);
  assign age     = now_r - rd_data_r[dedup_pkg::TIME_W-1:0];
  assign expired = (age > retention);

  assign sts.op_clear = (kind_r == dedup_pkg::KIND_CLEAR);
  assign sts.last_idx = (idx_r == dedup_pkg::IDX_W'(dedup_pkg::ENTRIES - 1));

  // Latch the item.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r   <= dedup_pkg::kind_t'(in_kind);
      key_hi_r <= in_key_high;
      key_lo_r <= in_key_low;
      now_r    <= in_now_seconds;
    end
  end

  // Key memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_idx] <= {key_hi_r, key_lo_r, now_r};
    if (cmd.scan) rd_data_r <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      rd_vld_r <= 1'b0;
      rd_idx_r <= '0;
    end else begin
      rd_vld_r <= cmd.scan;
      if (cmd.load) begin
        idx_r <= '0;
      end else if (cmd.scan) begin
        idx_r    <= idx_r + dedup_pkg::IDX_W'(1);
        rd_idx_r <= idx_r;
      end
    end
  end

  // Track first match, first free slot and first expired slot of the walk.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_f_r <= 1'b0;
      free_f_r  <= 1'b0;
      exp_f_r   <= 1'b0;
    end else if (cmd.load) begin
      match_f_r <= 1'b0;
      free_f_r  <= 1'b0;
      exp_f_r   <= 1'b0;
    end else if (rd_vld_r) begin
      if (!match_f_r && hit) begin
        match_f_r <= 1'b1;
        match_exp_r <= expired;
        match_idx_r <= rd_idx_r;
      end
      if (!free_f_r && !slot_v) begin
        free_f_r   <= 1'b1;
        free_idx_r <= rd_idx_r;
      end
      if (!exp_f_r && slot_v && expired) begin
        exp_f_r   <= 1'b1;
        exp_idx_r <= rd_idx_r;
      end
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    count_nxt = count_r;
    wr_en     = 1'b0;
    wr_idx    = match_idx_r;
    dup_nxt   = 1'b0;
    full_nxt  = 1'b0;
    // sweep drops each expired entry as the walk passes it
    if (rd_vld_r && (kind_r == dedup_pkg::KIND_SWEEP) && slot_v && expired) begin
      valid_nxt[rd_idx_r] = 1'b0;
      count_nxt           = count_r - dedup_pkg::CNT_W'(1);
    end
    if (cmd.finish) begin
      unique case (kind_r)
        dedup_pkg::KIND_QUERY: begin
          if (match_f_r) begin
            if (match_exp_r) begin
              valid_nxt[match_idx_r] = 1'b0;
              count_nxt              = count_r - dedup_pkg::CNT_W'(1);
            end else begin
              dup_nxt = 1'b1;
            end
          end
        end
        dedup_pkg::KIND_MARK: begin
          if (match_f_r) begin
            wr_en = 1'b1;
          end else if (free_f_r) begin
            wr_en     = 1'b1;
            wr_idx    = free_idx_r;
            count_nxt = count_r + dedup_pkg::CNT_W'(1);
          end else if (exp_f_r) begin
            wr_en  = 1'b1;
            wr_idx = exp_idx_r;
          end else begin
            full_nxt = 1'b1;
          end
          if (wr_en) valid_nxt[wr_idx] = 1'b1;
        end
        dedup_pkg::KIND_SWEEP: ;
        dedup_pkg::KIND_CLEAR: begin
          valid_nxt = '0;
          count_nxt = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      count_r     <= count_nxt;
      out_valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      dup_r     <= dup_nxt;
      full_r    <= full_nxt;
      out_cnt_r <= count_nxt;
    end
  end

  assign cnt_ext         = 32'(out_cnt_r);
  assign out_valid       = out_valid_r;
  assign out_duplicate   = dup_r;
  assign out_full_res    = full_r;
  assign out_entry_count = cnt_ext[dedup_pkg::OUT_CNT_W-1:0];

endmodule

// ===== rtl/core/dedup_table_with_expiry_core.sv =====
// Top level of the dedup table core: register port, sequencer and datapath.
`timescale 1ns / 1ps
// Duplicate detection table of 16 keys of 128 bits with a time mark each. An
// item is taken when start is high and busy is low. Query, mark and sweep walk
// every slot through the single read port of the key memory, one slot per
// cycle; a clear skips the walk. The result shows on the out_ ports for one
// cycle with out_valid high, and busy falls in that same cycle, so the next
// item can be taken there. The receiver cannot stall the result. Valid bits
// sit in flip-flops cleared by reset, so no clearing pass follows reset.
// retention_seconds sits at byte address 0 and may be written only while
// busy is low; a write of zero stores one.
module dedup_table_with_expiry_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [1:0]                             in_kind,
  input  logic [dedup_pkg::KEY_W-1:0]            in_key_high,
  input  logic [dedup_pkg::KEY_W-1:0]            in_key_low,
  input  logic [dedup_pkg::TIME_W-1:0]           in_now_seconds,
  output logic                                   out_valid,
  output logic                                   out_duplicate,
  output logic                                   out_full_res,
  output logic [dedup_pkg::OUT_CNT_W-1:0]        out_entry_count,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [dedup_pkg::CFG_ADDR_W-1:0]       paddr,
  input  logic [dedup_pkg::CFG_DATA_W-1:0]       pwdata,
  output logic [dedup_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                   pready
);

  dedup_pkg::cmd_t cmd;
  dedup_pkg::sts_t sts;

  logic [dedup_pkg::TIME_W-1:0] retention_r, retention_nxt;
  logic                         reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[dedup_pkg::CFG_ADDR_W-1:2] == dedup_pkg::REG_RETENTION);
  assign prdata  = reg_hit ? retention_r : '0;

  always_comb begin
    retention_nxt = retention_r;
    if (psel && penable && pwrite && pready && reg_hit) begin
      // clamp zero to the smallest legal retention
      retention_nxt = (pwdata == '0) ? dedup_pkg::TIME_W'(1) : pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) retention_r <= dedup_pkg::RETENTION_RESET;
    else        retention_r <= retention_nxt;
  end

  dedup_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  dedup_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_kind         (in_kind),
    .in_key_high     (in_key_high),
    .in_key_low      (in_key_low),
    .in_now_seconds  (in_now_seconds),
    .retention       (retention_r),
    .out_valid       (out_valid),
    .out_duplicate   (out_duplicate),
    .out_full_res    (out_full_res),
    .out_entry_count (out_entry_count)
  );

endmodule

// ===== rtl/core/dedup_checker.sv =====
// Port-level checks of the dedup table core and their bind.
`timescale 1ns / 1ps
`include "dedup_table_with_expiry_core_macros.svh"
module dedup_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                start,
  input logic                                busy,
  input logic                                out_valid,
  input logic                                out_duplicate,
  input logic                                out_full_res,
  input logic [dedup_pkg::OUT_CNT_W-1:0]     out_entry_count
);

  // an accepted item always occupies the block for the next cycle
  `DEDUP_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // a result shows only once the block is free again
  `DEDUP_ASSERT_NOW(a_result_idle, out_valid, !busy)
  // one result per item: the strobe lasts a single cycle
  `DEDUP_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid)
  // a full mark never reports a duplicate
  `DEDUP_ASSERT_NOW(a_full_not_dup, out_valid && out_full_res, !out_duplicate)
  // the reported count never exceeds the table size
  `DEDUP_ASSERT_NOW(a_count_range, out_valid, out_entry_count <= dedup_pkg::OUT_CNT_W'(dedup_pkg::ENTRIES))

endmodule

bind dedup_table_with_expiry_core dedup_checker u_dedup_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_duplicate   (out_duplicate),
  .out_full_res    (out_full_res),
  .out_entry_count (out_entry_count)
);
